// File: hdl/awd_pkg.sv
// ----------------------------------------------------------------------------
// awd_pkg: shared types and constants of the waveshaper distortion block
// Curve codes, fixed Q-format constants and pipeline depths used by the
// top level and the curve shaper.
// ----------------------------------------------------------------------------
package awd_pkg;

    // Curve selection register codes
    typedef enum logic [2:0] {
        CURVE_SOFT  = 3'd0,
        CURVE_HARD  = 3'd1,
        CURVE_TANH  = 3'd2,
        CURVE_CUBIC = 3'd3,
        CURVE_PASS  = 3'd4
    } clip_mode_t;

    // Default build parameters
    localparam int AWD_SAMPLE_BITS = 24;
    localparam int AWD_TANH_DEPTH  = 256;

    // Driven sample x and curve output y are signed Q.23 words of this width
    localparam int AWD_X_W = 32;

    // Soft curve quotient bits, one per divider stage
    localparam int AWD_DIV_STEPS = 23;

    // Shaper latency: operand stage, divider steps, output select
    localparam int AWD_SHAPE_LAT = AWD_DIV_STEPS + 2;

    // Stages of the tanh / cubic path, its result register included
    localparam int AWD_ALT_LAT = 4;

endpackage

// File: hdl/audio_waveshaper_distortion.sv
// ----------------------------------------------------------------------------
// audio_waveshaper_distortion: overdrive waveshaper with bus accumulation
// Drive, curve, gain, mix-in and saturation on a streaming sample path.
// ----------------------------------------------------------------------------
// Takes one sample beat per clock unless m_ready stalls and returns one
// result beat per sample through AWD_SHAPE_LAT + 3 (28) register stages,
// a depth set by the soft curve divider, which resolves one quotient bit
// per stage over 23 stages; the other curves are delayed to match. A stall
// on m_ready freezes the whole pipeline. The user must write the curve
// register (cfg_data) only while no sample is in flight; the block does
// not enforce it. Codes 5 to 7 give a silent curve; the bus value passes on.
// ----------------------------------------------------------------------------
module audio_waveshaper_distortion #(
    parameter int SAMPLE_BITS      = awd_pkg::AWD_SAMPLE_BITS,
    parameter int TANH_TABLE_DEPTH = awd_pkg::AWD_TANH_DEPTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [2:0]                    cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_sample_in,
    input  logic signed [15:0]            s_drive,
    input  logic signed [15:0]            s_gain,
    input  logic signed [SAMPLE_BITS-1:0] s_mix_in,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_mix_out
);
    import awd_pkg::*;

    localparam int PRW   = SAMPLE_BITS + 16;
    localparam int ZW    = SAMPLE_BITS + 15;
    localparam int NSTG  = AWD_SHAPE_LAT + 3;

    // Saturation bounds of the bus sum
    localparam logic signed [ZW:0] SUM_MAX = (ZW+1)'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
    localparam logic signed [ZW:0] SUM_MIN = -SUM_MAX - (ZW+1)'(1);

    clip_mode_t                clip_mode_reg;
    logic                      vld_reg [NSTG];
    logic                      adv;
    logic signed [PRW-1:0]     dprod;
    logic signed [AWD_X_W-1:0] x_reg;
    logic signed [15:0]        g_reg;
    logic signed [SAMPLE_BITS-1:0] mix_reg;
    logic signed [15:0]        g_dly_reg   [AWD_SHAPE_LAT];
    logic signed [SAMPLE_BITS-1:0] mix_dly_reg [AWD_SHAPE_LAT];
    logic signed [AWD_X_W-1:0] y_shaped;
    logic signed [47:0]        yg;
    logic signed [ZW-1:0]      z_reg;
    logic signed [SAMPLE_BITS-1:0] mix_z_reg;
    logic signed [ZW:0]        sum;
    logic signed [SAMPLE_BITS-1:0] sat_next;
    logic signed [SAMPLE_BITS-1:0] out_reg;

    // Advance whenever the output slot is free or being emptied
    assign adv       = !vld_reg[NSTG-1] || m_ready;
    assign s_ready   = adv;
    assign cfg_ready = 1'b1;

    // Curve register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clip_mode_reg <= CURVE_SOFT;
        end else if (cfg_valid && cfg_ready) begin
            clip_mode_reg <= clip_mode_t'(cfg_data);
        end
    end

    // Valid bits travel with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NSTG; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else if (adv) begin
            vld_reg[0] <= s_valid;
            for (int i = 1; i < NSTG; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // Apply drive
    assign dprod = PRW'(s_sample_in) * PRW'(s_drive);

    always_ff @(posedge aclk) begin
        if (adv) begin
            x_reg   <= AWD_X_W'(dprod >>> (SAMPLE_BITS - 16));
            g_reg   <= s_gain;
            mix_reg <= s_mix_in;
        end
    end

    awd_shaper #(
        .TANH_TABLE_DEPTH (TANH_TABLE_DEPTH)
    ) u_shaper (
        .aclk  (aclk),
        .adv   (adv),
        .mode  (clip_mode_reg),
        .x_in  (x_reg),
        .y_out (y_shaped)
    );

    // Carry gain and bus value alongside the shaper
    always_ff @(posedge aclk) begin
        if (adv) begin
            g_dly_reg[0]   <= g_reg;
            mix_dly_reg[0] <= mix_reg;
            for (int i = 1; i < AWD_SHAPE_LAT; i++) begin
                g_dly_reg[i]   <= g_dly_reg[i-1];
                mix_dly_reg[i] <= mix_dly_reg[i-1];
            end
        end
    end

    // Apply gain and rescale to the sample format
    assign yg = 48'(y_shaped) * 48'(g_dly_reg[AWD_SHAPE_LAT-1]);

    always_ff @(posedge aclk) begin
        if (adv) begin
            z_reg     <= ZW'(yg >>> (32 - SAMPLE_BITS));
            mix_z_reg <= mix_dly_reg[AWD_SHAPE_LAT-1];
        end
    end

    // Add to the bus and saturate
    always_comb begin
        sum = (ZW+1)'(mix_z_reg) + (ZW+1)'(z_reg);
        if (sum > SUM_MAX) begin
            sat_next = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end else if (sum < SUM_MIN) begin
            sat_next = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end else begin
            sat_next = SAMPLE_BITS'(sum);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_reg <= sat_next;
        end
    end

    assign m_valid   = vld_reg[NSTG-1];
    assign m_mix_out = out_reg;

`ifndef SYNTHESIS
    // An accepted beat enters the first stage
    a_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> vld_reg[0])
        else $error("accepted beat missing from first stage");

    // A stall freezes the valid bits, checked at the second stage and the output
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> vld_reg[1] == $past(vld_reg[1]) && m_valid == $past(m_valid))
        else $error("pipeline moved during stall");

    // The second to last valid stage reaches the output when the pipe advances
    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && vld_reg[NSTG-2] |=> m_valid)
        else $error("beat lost before output");
`endif

endmodule

// File: hdl/awd_soft_div.sv
// ----------------------------------------------------------------------------
// awd_soft_div: pipelined divider for the soft curve
// Forms |x| * 2^23 / (2^23 + |x|) one quotient bit per stage, restoring.
// ----------------------------------------------------------------------------
module awd_soft_div (
    input  logic                           aclk,
    input  logic                           adv,
    input  logic signed [awd_pkg::AWD_X_W-1:0] x_in,
    output logic [awd_pkg::AWD_DIV_STEPS-1:0]  q_mag,
    output logic                           q_neg
);
    import awd_pkg::*;

    localparam int RW = AWD_X_W - 1;

    logic [RW-1:0]            rem_reg [AWD_DIV_STEPS+1];
    logic [RW-1:0]            den_reg [AWD_DIV_STEPS+1];
    logic [AWD_DIV_STEPS-1:0] quo_reg [AWD_DIV_STEPS+1];
    logic                     neg_reg [AWD_DIV_STEPS+1];
    logic [RW-1:0]            ax;

    // Take the magnitude; it is already below the divisor
    assign ax = x_in[AWD_X_W-1] ? RW'(-x_in) : RW'(x_in);

    // Load operands, then one restoring step per stage
    always_ff @(posedge aclk) begin
        if (adv) begin
            rem_reg[0] <= ax;
            den_reg[0] <= ax + RW'(32'h0080_0000);
            quo_reg[0] <= '0;
            neg_reg[0] <= x_in[AWD_X_W-1];
            for (int i = 1; i <= AWD_DIV_STEPS; i++) begin
                if ({rem_reg[i-1], 1'b0} >= {1'b0, den_reg[i-1]}) begin
                    rem_reg[i] <= RW'({rem_reg[i-1], 1'b0} - {1'b0, den_reg[i-1]});
                    quo_reg[i] <= {quo_reg[i-1][AWD_DIV_STEPS-2:0], 1'b1};
                end else begin
                    rem_reg[i] <= RW'({rem_reg[i-1], 1'b0});
                    quo_reg[i] <= {quo_reg[i-1][AWD_DIV_STEPS-2:0], 1'b0};
                end
                den_reg[i] <= den_reg[i-1];
                neg_reg[i] <= neg_reg[i-1];
            end
        end
    end

    assign q_mag = quo_reg[AWD_DIV_STEPS];
    assign q_neg = neg_reg[AWD_DIV_STEPS];

endmodule

// File: hdl/awd_shaper.sv
// ----------------------------------------------------------------------------
// awd_shaper: transfer curve stage of the waveshaper
// Soft, hard, tanh (table with interpolation), cubic and pass-through
// curves, all pipelined to a common latency.
// ----------------------------------------------------------------------------
module awd_shaper #(
    parameter int TANH_TABLE_DEPTH = awd_pkg::AWD_TANH_DEPTH
) (
    input  logic                               aclk,
    input  logic                               adv,
    input  awd_pkg::clip_mode_t                mode,
    input  logic signed [awd_pkg::AWD_X_W-1:0] x_in,
    output logic signed [awd_pkg::AWD_X_W-1:0] y_out
);
    import awd_pkg::*;

    localparam int IW      = $clog2(TANH_TABLE_DEPTH);
    localparam int PW      = AWD_X_W + $clog2(TANH_TABLE_DEPTH + 1);
    localparam int ALT_DLY = AWD_SHAPE_LAT - 1 - AWD_ALT_LAT;

    // Table entry k: tanh(8k/D) in Q.23 via a series for exp and squaring
    function automatic logic [23:0] tanh_entry(input int unsigned k);
        logic [63:0] t;
        logic [63:0] term;
        logic [63:0] e;
        logic [63:0] num;
        logic [63:0] dnm;
        logic [63:0] quo;
        logic [63:0] rem;
        t    = (64'(k) << 27) / TANH_TABLE_DEPTH;
        term = 64'd1 << 31;
        e    = 64'd1 << 31;
        term = ((term * t) >> 31);     e = e - term;
        term = ((term * t) >> 31) / 2; e = e + term;
        term = ((term * t) >> 31) / 3; e = e - term;
        term = ((term * t) >> 31) / 4; e = e + term;
        term = ((term * t) >> 31) / 5; e = e - term;
        term = ((term * t) >> 31) / 6; e = e + term;
        term = ((term * t) >> 31) / 7; e = e - term;
        for (int i = 0; i < 8; i++) begin
            e = (e * e) >> 31;
        end
        num = (((64'd1 << 31) - e) << 24) + ((64'd1 << 31) + e);
        dnm = ((64'd1 << 31) + e) << 1;
        // Long division, one quotient bit per pass
        quo = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[62:0], num[i]};
            if (rem >= dnm) begin
                rem    = rem - dnm;
                quo[i] = 1'b1;
            end
        end
        return 24'(quo);
    endfunction

    localparam logic [23:0] TANH_LAST = tanh_entry(TANH_TABLE_DEPTH);

    // Table rows hold the entry pair {T[k+1], T[k]}
    logic [47:0] tanh_pair [TANH_TABLE_DEPTH];
    for (genvar gi = 0; gi < TANH_TABLE_DEPTH; gi++) begin : g_rom
        assign tanh_pair[gi] = {tanh_entry(gi + 1), tanh_entry(gi)};
    end

    // Stage 1 operands
    logic [AWD_X_W-2:0]        ax;
    logic [PW-1:0]             p_full;
    logic [PW-1:0]             p_pos;
    logic signed [24:0]        c_clamp;
    logic signed [AWD_X_W-1:0] x1_reg, x2_reg, x3_reg;
    logic signed [24:0]        c1_reg, c2_reg;
    logic [IW-1:0]             t_idx_reg;
    logic [22:0]               t_f1_reg, t_f2_reg;
    logic                      t_sat1_reg, t_sat2_reg;
    logic                      t_neg1_reg, t_neg2_reg, t_neg3_reg;
    logic [23:0]               x2q_reg;
    logic [47:0]               pair_reg;
    logic signed [49:0]        cx_reg;
    logic signed [49:0]        c3_reg;
    logic signed [48:0]        t_prod_reg;
    logic [23:0]               t_k_reg;
    logic [23:0]               t_k_sel;
    logic signed [24:0]        t_diff;
    logic signed [AWD_X_W-1:0] y_tanh;
    logic signed [AWD_X_W-1:0] y_cubic;
    logic signed [AWD_X_W-1:0] y_hard;
    logic signed [AWD_X_W-1:0] y_alt_next;
    logic signed [AWD_X_W-1:0] y_alt_reg;
    logic signed [AWD_X_W-1:0] alt_dly_reg [ALT_DLY];
    logic signed [AWD_X_W-1:0] y_soft;
    logic signed [AWD_X_W-1:0] y_next;
    logic signed [AWD_X_W-1:0] y_reg;
    logic [AWD_DIV_STEPS-1:0]  q_mag;
    logic                      q_neg;

    awd_soft_div u_div (
        .aclk  (aclk),
        .adv   (adv),
        .x_in  (x_in),
        .q_mag (q_mag),
        .q_neg (q_neg)
    );

    // Clamp to the unit range for the cubic curve
    always_comb begin
        if (x_in < -AWD_X_W'(32'sh0080_0000)) begin
            c_clamp = -25'sh080_0000;
        end else if (x_in > AWD_X_W'(32'sh0080_0000)) begin
            c_clamp = 25'sh080_0000;
        end else begin
            c_clamp = 25'(x_in);
        end
    end

    // Scale |x| to the table index and fraction
    assign ax     = x_in[AWD_X_W-1] ? (AWD_X_W-1)'(-x_in) : (AWD_X_W-1)'(x_in);
    assign p_full = PW'(ax) * PW'(TANH_TABLE_DEPTH);
    assign p_pos  = p_full >> 3;

    // Stage 1: clamp, table index
    always_ff @(posedge aclk) begin
        if (adv) begin
            x1_reg     <= x_in;
            c1_reg     <= c_clamp;
            t_idx_reg  <= IW'(p_pos >> 23);
            t_f1_reg   <= p_pos[22:0];
            t_sat1_reg <= (p_pos >> 23) >= PW'(TANH_TABLE_DEPTH);
            t_neg1_reg <= x_in[AWD_X_W-1];
        end
    end

    // Stage 2: square for cubic, fetch the table pair
    always_ff @(posedge aclk) begin
        if (adv) begin
            x2_reg     <= x1_reg;
            c2_reg     <= c1_reg;
            x2q_reg    <= 24'((50'(c1_reg) * 50'(c1_reg)) >> 23);
            pair_reg   <= tanh_pair[t_idx_reg];
            t_f2_reg   <= t_f1_reg;
            t_sat2_reg <= t_sat1_reg;
            t_neg2_reg <= t_neg1_reg;
        end
    end

    // Hold the last entry beyond the table
    assign t_k_sel = t_sat2_reg ? TANH_LAST : pair_reg[23:0];
    assign t_diff  = t_sat2_reg ? '0
                   : $signed({1'b0, pair_reg[47:24]}) - $signed({1'b0, pair_reg[23:0]});

    // Stage 3: cubic product, interpolation product
    always_ff @(posedge aclk) begin
        if (adv) begin
            x3_reg     <= x2_reg;
            cx_reg     <= 50'(c2_reg) * 50'($signed({1'b0, x2q_reg}));
            c3_reg     <= (50'(c2_reg) * 50'sd3) <<< 23;
            t_prod_reg <= 49'(t_diff) * 49'($signed({1'b0, t_f2_reg}));
            t_k_reg    <= t_k_sel;
            t_neg3_reg <= t_neg2_reg;
        end
    end

    // Finish tanh, cubic and hard curves
    always_comb begin
        y_tanh = AWD_X_W'($signed({1'b0, t_k_reg})) + AWD_X_W'(t_prod_reg >>> 23);
        if (t_neg3_reg) begin
            y_tanh = -y_tanh;
        end
        y_cubic = AWD_X_W'((51'(c3_reg) - 51'(cx_reg)) >>> 24);
        if (x3_reg < AWD_X_W'(-32'sh0080_0000)) begin
            y_hard = AWD_X_W'(-32'sh0080_0000);
        end else if (x3_reg > AWD_X_W'(32'sh0080_0000)) begin
            y_hard = AWD_X_W'(32'sh0080_0000);
        end else begin
            y_hard = x3_reg;
        end
    end

    // Pick the non-divider curve
    always_comb begin
        case (mode)
            CURVE_HARD:  y_alt_next = y_hard;
            CURVE_TANH:  y_alt_next = y_tanh;
            CURVE_CUBIC: y_alt_next = y_cubic;
            CURVE_PASS:  y_alt_next = x3_reg;
            default:     y_alt_next = '0;
        endcase
    end

    // Stage 4 and delay line up to the divider output
    always_ff @(posedge aclk) begin
        if (adv) begin
            y_alt_reg      <= y_alt_next;
            alt_dly_reg[0] <= y_alt_reg;
            for (int i = 1; i < ALT_DLY; i++) begin
                alt_dly_reg[i] <= alt_dly_reg[i-1];
            end
        end
    end

    // Apply the sign to the soft quotient and select
    assign y_soft = q_neg ? -AWD_X_W'(q_mag) : AWD_X_W'(q_mag);
    assign y_next = (mode == CURVE_SOFT) ? y_soft : alt_dly_reg[ALT_DLY-1];

    always_ff @(posedge aclk) begin
        if (adv) begin
            y_reg <= y_next;
        end
    end

    assign y_out = y_reg;

endmodule
